### rtl/core/skf16_pkg.sv
`timescale 1ns / 1ps
// Shared constants, widths and control types for the scalar Kalman filter.
package skf16_pkg;

  // Fixed-point format
  localparam int FRAC_BITS  = 16;
  localparam int SAMPLE_W   = 16;
  localparam int VAR_W      = 32;
  localparam int EST_W      = SAMPLE_W + FRAC_BITS;   // signed estimate, Q.F
  localparam int DIFF_W     = EST_W + 1;              // residual and its magnitude
  localparam int GAIN_W     = FRAC_BITS + 1;          // gain in Q1.F, 1.0 included
  localparam int SUM_W      = VAR_W + 1;              // p + r without wrap
  localparam int REM_W      = VAR_W + 2;              // divider partial remainder
  localparam int PROD_W     = DIFF_W + GAIN_W;        // shared multiplier result
  localparam int CNT_W      = $clog2(GAIN_W);         // quotient bit counter

  localparam logic [GAIN_W-1:0] GAIN_ONE = GAIN_W'(1) << FRAC_BITS;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_INIT_EST   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INIT_VAR   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PROC_NOISE = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MEAS_NOISE = 2'd3;

  // Register reset values
  localparam logic [SAMPLE_W-1:0] INIT_EST_RST   = 16'h0000;
  localparam logic [VAR_W-1:0]    INIT_VAR_RST   = 32'd65536;
  localparam logic [VAR_W-1:0]    PROC_NOISE_RST = 32'd655;
  localparam logic [VAR_W-1:0]    MEAS_NOISE_RST = 32'd65536;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;   // latch the incoming sample
    logic predict;   // p = sat(var + q), den = p + r, start divider
    logic div_step;  // one restoring division step
    logic mul_est;   // product = |residual| * gain
    logic est_upd;   // apply the correction to the estimate
    logic mul_var;   // product = p * (1 - gain)
    logic finish;    // store new variance and output value
  } skf16_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic div_last;  // current division step produces the last quotient bit
  } skf16_status_t;

endpackage

### rtl/core/skf16_stream_if.sv
`timescale 1ns / 1ps
// Valid/ready stream interfaces for sample beats and result beats.
interface skf16_meas_if
  import skf16_pkg::*;
();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] measurement;

  modport source (output valid, output measurement, input ready);
  modport sink   (input valid, input measurement, output ready);
endinterface

interface skf16_filt_if
  import skf16_pkg::*;
();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] filtered_value;

  modport source (output valid, output filtered_value, input ready);
  modport sink   (input valid, input filtered_value, output ready);
endinterface

### rtl/core/scalar_kalman_filter_int16_unit.sv
`timescale 1ns / 1ps
// A result beat is registered by the finish step of its sample's update; a new
// sample waits until it is done. The restoring divider's 17 quotient bits, one
// per cycle, set most of the update, plus two passes through one multiplier.
// A pending result beat does not block the next sample; a second result waits.
// Reset (synchronous, active high) restores the register defaults and loads
// the estimate and variance from them; writing register 0 or 1 reloads both.
module scalar_kalman_filter_int16_unit
  import skf16_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  skf16_meas_if.sink            sample_in,
  skf16_filt_if.source          result_out
);

  skf16_cmd_t    cmd;
  skf16_status_t status;
  logic          in_ready;
  logic          out_valid;

  assign sample_in.ready  = in_ready;
  assign result_out.valid = out_valid;

  // Sequencer
  skf16_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sample_in.valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (result_out.ready),
    .status    (status),
    .cmd       (cmd)
  );

  // Arithmetic and state
  skf16_datapath u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .measurement    (sample_in.measurement),
    .cmd            (cmd),
    .status         (status),
    .filtered_value (result_out.filtered_value)
  );

  // An accepted sample starts the predict step next cycle
  assert property (@(posedge clk) disable iff (rst)
    (sample_in.valid && in_ready) |=> cmd.predict)
    else $error("accepted sample did not start predict");

  // At most one command per cycle
  assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.capture, cmd.predict, cmd.div_step, cmd.mul_est,
              cmd.est_upd, cmd.mul_var, cmd.finish}))
    else $error("overlapping datapath commands");

  // No new sample is taken while an update is in progress
  assert property (@(posedge clk) disable iff (rst)
    (cmd.div_step || cmd.mul_est || cmd.mul_var) |-> !in_ready)
    else $error("input ready during update");

  // Finishing an update always presents a result beat
  assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> out_valid)
    else $error("finished update without result beat");

endmodule

### rtl/core/skf16_ctrl.sv
`timescale 1ns / 1ps
// Sequencer for the filter: steps the datapath through one update per sample.
module skf16_ctrl
  import skf16_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  input  skf16_status_t status,
  output skf16_cmd_t    cmd
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_PRED = 3'd1;
  localparam logic [2:0] ST_DIV  = 3'd2;
  localparam logic [2:0] ST_MULE = 3'd3;
  localparam logic [2:0] ST_EST  = 3'd4;
  localparam logic [2:0] ST_MULV = 3'd5;
  localparam logic [2:0] ST_FIN  = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       out_free;

  // result register can take a new value
  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == ST_IDLE);

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = ST_PRED;
        end
      end
      ST_PRED: begin
        cmd.predict = 1'b1;
        state_next  = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_next = ST_MULE;
        end
      end
      ST_MULE: begin
        cmd.mul_est = 1'b1;
        state_next  = ST_EST;
      end
      ST_EST: begin
        cmd.est_upd = 1'b1;
        state_next  = ST_MULV;
      end
      ST_MULV: begin
        cmd.mul_var = 1'b1;
        state_next  = ST_FIN;
      end
      ST_FIN: begin
        // hold here while the previous result beat is still pending
        if (out_free) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Result valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

### rtl/core/skf16_datapath.sv
`timescale 1ns / 1ps
// Filter datapath: config registers, state, bit-serial divider, shared multiplier.
module skf16_datapath
  import skf16_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [CFG_DATA_W-1:0]      cfg_data,
  input  logic signed [SAMPLE_W-1:0] measurement,
  input  skf16_cmd_t                 cmd,
  output skf16_status_t              status,
  output logic signed [SAMPLE_W-1:0] filtered_value
);

  // Configuration registers
  logic [SAMPLE_W-1:0] init_est;
  logic [VAR_W-1:0]    init_var;
  logic [VAR_W-1:0]    proc_noise;
  logic [VAR_W-1:0]    meas_noise;

  // Filter state
  logic [EST_W-1:0]    estimate;
  logic [VAR_W-1:0]    error_variance;

  // Per-sample working registers
  logic [SAMPLE_W-1:0] meas;
  logic [VAR_W-1:0]    p;
  logic [SUM_W-1:0]    den;
  logic [REM_W-1:0]    div_rem;
  logic [GAIN_W-1:0]   gain;
  logic [CNT_W-1:0]    div_cnt;
  logic                diff_neg;
  logic [PROD_W-1:0]   prod;

  // Combinational terms
  logic [SUM_W-1:0]    p_sum;
  logic [VAR_W-1:0]    p_sat;
  logic [REM_W-1:0]    den_ext;
  logic                div_ge;
  logic [REM_W-1:0]    div_left;
  logic [GAIN_W-1:0]   gain_eff;
  logic [DIFF_W-1:0]   diff;
  logic [DIFF_W-1:0]   mag;
  logic [DIFF_W-1:0]   mul_a;
  logic [GAIN_W-1:0]   mul_b;
  logic [DIFF_W-1:0]   corr;
  logic [DIFF_W-1:0]   est_ext;
  logic [DIFF_W-1:0]   est_new;
  logic [DIFF_W-1:0]   est_round;

  function automatic logic [EST_W-1:0] to_fix(input logic [SAMPLE_W-1:0] v);
    return {v, {FRAC_BITS{1'b0}}};
  endfunction

  // Predict: saturating p + q, then the gain denominator
  assign p_sum = {1'b0, error_variance} + {1'b0, proc_noise};
  assign p_sat = p_sum[VAR_W] ? {VAR_W{1'b1}} : p_sum[VAR_W-1:0];

  // Restoring division step, one quotient bit per cycle
  assign den_ext  = {1'b0, den};
  assign div_ge   = (div_rem >= den_ext);
  assign div_left = div_ge ? (div_rem - den_ext) : div_rem;
  assign status.div_last = (div_cnt == CNT_W'(FRAC_BITS));

  // zero denominator gives zero gain
  assign gain_eff = (den == '0) ? '0 : gain;

  // Residual in Q.F and its magnitude
  assign diff = {meas[SAMPLE_W-1], to_fix(meas)} - {estimate[EST_W-1], estimate};
  assign mag  = diff[DIFF_W-1] ? (~diff + DIFF_W'(1)) : diff;

  // Shared multiplier operands
  assign mul_a = cmd.mul_var ? DIFF_W'(p) : mag;
  assign mul_b = cmd.mul_var ? (GAIN_ONE - gain_eff) : gain_eff;

  // Correction rounds toward zero: magnitude is scaled, then signed
  assign corr    = prod[FRAC_BITS +: DIFF_W];
  assign est_ext = {estimate[EST_W-1], estimate};
  assign est_new = diff_neg ? (est_ext - corr) : (est_ext + corr);

  // Truncate the estimate toward zero to whole samples
  assign est_round = est_ext +
                     (estimate[EST_W-1] ? DIFF_W'((1 << FRAC_BITS) - 1) : '0);

  // Configuration writes and filter state
  always_ff @(posedge clk) begin
    if (rst) begin
      init_est       <= INIT_EST_RST;
      init_var       <= INIT_VAR_RST;
      proc_noise     <= PROC_NOISE_RST;
      meas_noise     <= MEAS_NOISE_RST;
      estimate       <= to_fix(INIT_EST_RST);
      error_variance <= INIT_VAR_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_INIT_EST: begin
          init_est       <= cfg_data[SAMPLE_W-1:0];
          estimate       <= to_fix(cfg_data[SAMPLE_W-1:0]);
          error_variance <= init_var;
        end
        REG_INIT_VAR: begin
          init_var       <= cfg_data[VAR_W-1:0];
          estimate       <= to_fix(init_est);
          error_variance <= cfg_data[VAR_W-1:0];
        end
        REG_PROC_NOISE: begin
          proc_noise <= cfg_data[VAR_W-1:0];
        end
        REG_MEAS_NOISE: begin
          meas_noise <= cfg_data[VAR_W-1:0];
        end
        default: begin
        end
      endcase
    end else begin
      if (cmd.est_upd) begin
        estimate <= est_new[EST_W-1:0];
      end
      if (cmd.finish) begin
        error_variance <= prod[FRAC_BITS +: VAR_W];
      end
    end
  end

  // Divider bit counter
  always_ff @(posedge clk) begin
    if (rst) begin
      div_cnt <= '0;
    end else if (cmd.predict) begin
      div_cnt <= '0;
    end else if (cmd.div_step) begin
      div_cnt <= div_cnt + CNT_W'(1);
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      meas <= measurement;
    end
    if (cmd.predict) begin
      p       <= p_sat;
      den     <= {1'b0, p_sat} + {1'b0, meas_noise};
      div_rem <= REM_W'(p_sat);
      gain    <= '0;
    end
    if (cmd.div_step) begin
      div_rem <= {div_left[REM_W-2:0], 1'b0};
      gain    <= {gain[GAIN_W-2:0], div_ge};
    end
    if (cmd.mul_est) begin
      diff_neg <= diff[DIFF_W-1];
    end
    if (cmd.mul_est || cmd.mul_var) begin
      prod <= PROD_W'(mul_a) * PROD_W'(mul_b);
    end
    if (cmd.finish) begin
      filtered_value <= est_round[FRAC_BITS +: SAMPLE_W];
    end
  end

endmodule
